@@ rtl/core/rchc_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull package
// Shared types, sizes and the fixed sample direction table.
// ----------------------------------------------------------------------------
package rchc_pkg;

  localparam int unsigned MaxStored    = 256;
  localparam int unsigned SampleCount  = 24;
  localparam int unsigned StoreAw      = $clog2(MaxStored);
  localparam int unsigned CountW       = $clog2(MaxStored + 1);
  localparam int unsigned SampleW      = $clog2(SampleCount);
  localparam int unsigned EntryW       = 24 + 24 + 23 + 23;
  localparam logic [15:0] BypassLimit  = 16'd4;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cz;
    logic [22:0]        ri;
    logic [22:0]        ro;
    logic               first;
    logic               bypass;
  } rchc_item_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SAMP_MUL = 5'b00010,
    ST_SAMP_ADD = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_EMIT     = 5'b10000
  } rchc_state_e;

  function automatic logic signed [17:0] dir_cos(input logic [SampleW-1:0] k);
    logic signed [17:0] v;
    case (k)
      5'd0:  v = 18'sd32768;
      5'd1:  v = 18'sd31651;
      5'd2:  v = 18'sd28378;
      5'd3:  v = 18'sd23170;
      5'd4:  v = 18'sd16384;
      5'd5:  v = 18'sd8481;
      5'd6:  v = 18'sd0;
      5'd7:  v = -18'sd8481;
      5'd8:  v = -18'sd16384;
      5'd9:  v = -18'sd23170;
      5'd10: v = -18'sd28378;
      5'd11: v = -18'sd31651;
      5'd12: v = -18'sd32768;
      5'd13: v = -18'sd31651;
      5'd14: v = -18'sd28378;
      5'd15: v = -18'sd23170;
      5'd16: v = -18'sd16384;
      5'd17: v = -18'sd8481;
      5'd18: v = 18'sd0;
      5'd19: v = 18'sd8481;
      5'd20: v = 18'sd16384;
      5'd21: v = 18'sd23170;
      5'd22: v = 18'sd28378;
      5'd23: v = 18'sd31651;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] dir_sin(input logic [SampleW-1:0] k);
    logic [SampleW-1:0] j;
    j = (k >= SampleW'(6)) ? k - SampleW'(6) : k + SampleW'(18);
    return dir_cos(j);
  endfunction

endpackage

@@ rtl/core/rchc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rchc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/rchc_front.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull front end
// Accepts rings, resolves set bypass and queues them for the back end.
// ----------------------------------------------------------------------------
module rchc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [23:0]   center_x_i,
  input  logic signed [23:0]   center_z_i,
  input  logic [22:0]          inner_radius_i,
  input  logic [22:0]          outer_radius_i,
  input  logic                 first_of_set_i,
  input  logic [15:0]          set_size_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  output logic                 q_valid_o,
  output rchc_pkg::rchc_item_t q_item_o,
  input  logic                 q_pop_i
);
  import rchc_pkg::*;

  rchc_item_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       cull_q;
  logic       bset_q, bset_d;
  logic       push;
  rchc_item_t item;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  always_comb begin
    bset_d      = first_of_set_i ? (set_size_i <= BypassLimit) : bset_q;
    item.cx     = center_x_i;
    item.cz     = center_z_i;
    item.ri     = inner_radius_i;
    item.ro     = outer_radius_i;
    item.first  = first_of_set_i;
    item.bypass = bset_d || !cull_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      cull_q   <= 1'b1;
      bset_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cull_q <= cfg_wdata_i;
      end
      if (push) begin
        bset_q   <= bset_d;
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i && q_valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ rtl/core/rchc_back.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull back end
// Tests each sample point against the kept table and emits surviving rings.
// ----------------------------------------------------------------------------
module rchc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rchc_pkg::rchc_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 result_valid_o,
  output logic signed [23:0]   kept_center_x_o,
  output logic signed [23:0]   kept_center_z_o,
  output logic [22:0]          kept_inner_radius_o,
  output logic [22:0]          kept_outer_radius_o,
  output logic [15:0]          kept_position_o,
  output logic                 table_overflow_o
);
  import rchc_pkg::*;

  rchc_state_e state_q, state_d;
  rchc_item_t  cur_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [15:0]        emit_q, emit_d;
  logic               store_q, store_d;
  logic [SampleW-1:0] k_q, k_d;
  logic [CountW-1:0]  issue_q, issue_d;
  logic signed [41:0] prod_x_q, prod_z_q;
  logic signed [25:0] sx_q, sz_q;

  logic               v1_q, v2_q, v3_q;
  logic [CountW-1:0]  idx1_q, idx2_q, idx3_q;
  logic signed [26:0] dx_q, dz_q;
  logic [22:0]        ro_s2_q, ri_s2_q;
  logic [53:0]        dx2_q, dz2_q;
  logic [45:0]        ro2_q, ri2_q;
  logic               rinz_q;

  logic [EntryW-1:0]  rdata;
  logic               re, we, flush, hit;
  logic [54:0]        d2;
  logic signed [41:0] rnd_x, rnd_z;

  assign d2  = {1'b0, dx2_q} + {1'b0, dz2_q};
  assign hit = v3_q && (d2 <= {9'd0, ro2_q}) && (!rinz_q || d2 >= {9'd0, ri2_q});
  assign re  = (state_q == ST_SCAN) && (issue_q < count_q) && !flush;
  assign we  = (state_q == ST_EMIT) && store_q && (count_q < CountW'(MaxStored));
  assign rnd_x = (prod_x_q + 42'sd16384) >>> 15;
  assign rnd_z = (prod_z_q + 42'sd16384) >>> 15;

  rchc_ram #(
    .Width(EntryW),
    .Depth(MaxStored)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[StoreAw-1:0]),
    .wdata_i({cur_q.cx, cur_q.cz, cur_q.ri, cur_q.ro}),
    .re_i   (re),
    .raddr_i(issue_q[StoreAw-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    emit_d  = emit_q;
    store_d = store_q;
    k_d     = k_q;
    issue_d = issue_q;
    flush   = 1'b0;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.first) begin
            count_d = '0;
            emit_d  = '0;
          end
          k_d     = '0;
          issue_d = '0;
          store_d = !q_item_i.bypass;
          if (q_item_i.bypass || count_d == '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SAMP_MUL;
          end
        end
      end
      ST_SAMP_MUL: state_d = ST_SAMP_ADD;
      ST_SAMP_ADD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (issue_q < count_q) begin
          issue_d = issue_q + CountW'(1);
        end
        if (hit) begin
          flush   = 1'b1;
          issue_d = '0;
          if (k_q == SampleW'(SampleCount - 1)) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + SampleW'(1);
            state_d = ST_SAMP_MUL;
          end
        end else if (v3_q && idx3_q == count_q - CountW'(1)) begin
          flush   = 1'b1;
          issue_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (we) begin
          count_d = count_q + CountW'(1);
        end
        if (emit_q != 16'hFFFF) begin
          emit_d = emit_q + 16'd1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      emit_q         <= '0;
      store_q        <= 1'b0;
      k_q            <= '0;
      issue_q        <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      emit_q         <= emit_d;
      store_q        <= store_d;
      k_q            <= k_d;
      issue_q        <= issue_d;
      v1_q           <= re;
      v2_q           <= v1_q && !flush;
      v3_q           <= v2_q && !flush;
      result_valid_o <= (state_q == ST_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (state_q == ST_SAMP_MUL) begin
      prod_x_q <= $signed({1'b0, cur_q.ro}) * dir_cos(k_q);
      prod_z_q <= $signed({1'b0, cur_q.ro}) * dir_sin(k_q);
    end
    if (state_q == ST_SAMP_ADD) begin
      sx_q <= 26'(cur_q.cx) + rnd_x[25:0];
      sz_q <= 26'(cur_q.cz) + rnd_z[25:0];
    end
    idx1_q  <= issue_q;
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
    dx_q    <= 27'($signed(rdata[93:70])) - 27'(sx_q);
    dz_q    <= 27'($signed(rdata[69:46])) - 27'(sz_q);
    ri_s2_q <= rdata[45:23];
    ro_s2_q <= rdata[22:0];
    dx2_q   <= 54'(dx_q * dx_q);
    dz2_q   <= 54'(dz_q * dz_q);
    ro2_q   <= 46'(ro_s2_q * ro_s2_q);
    ri2_q   <= 46'(ri_s2_q * ri_s2_q);
    rinz_q  <= (ri_s2_q != '0);
    if (state_q == ST_EMIT) begin
      kept_center_x_o     <= cur_q.cx;
      kept_center_z_o     <= cur_q.cz;
      kept_inner_radius_o <= cur_q.ri;
      kept_outer_radius_o <= cur_q.ro;
      kept_position_o     <= emit_q;
      table_overflow_o    <= store_q && !we;
    end
  end

endmodule

@@ rtl/core/ring_cluster_hull_cull.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull
// Drops rings whose outer circle is covered by rings already kept in the set.
// ----------------------------------------------------------------------------
// A bypassed ring or an empty table goes to emit; otherwise per sample
// the point is computed (multiply, then add) and the kept rings are
// scanned, one table read a cycle, until one covers it. A two-beat queue
// lets two rings wait. The receiver cannot stall. Reset clears the queue,
// counters and bypass flag and sets cull_enable; table contents are kept.
module ring_cluster_hull_cull (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_z_i,
  input  logic [22:0]        inner_radius_i,
  input  logic [22:0]        outer_radius_i,
  input  logic               first_of_set_i,
  input  logic [15:0]        set_size_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output logic               result_valid_o,
  output logic signed [23:0] kept_center_x_o,
  output logic signed [23:0] kept_center_z_o,
  output logic [22:0]        kept_inner_radius_o,
  output logic [22:0]        kept_outer_radius_o,
  output logic [15:0]        kept_position_o,
  output logic               table_overflow_o
);
  import rchc_pkg::*;

  logic       q_valid, q_pop;
  rchc_item_t q_item;

  rchc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .center_x_i    (center_x_i),
    .center_z_i    (center_z_i),
    .inner_radius_i(inner_radius_i),
    .outer_radius_i(outer_radius_i),
    .first_of_set_i(first_of_set_i),
    .set_size_i    (set_size_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  rchc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .result_valid_o     (result_valid_o),
    .kept_center_x_o    (kept_center_x_o),
    .kept_center_z_o    (kept_center_z_o),
    .kept_inner_radius_o(kept_inner_radius_o),
    .kept_outer_radius_o(kept_outer_radius_o),
    .kept_position_o    (kept_position_o),
    .table_overflow_o   (table_overflow_o)
  );

endmodule

@@ tb/rchc_checker.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull checker
// Watches the command, configuration and result ports, predicts the kept
// rings of every accepted beat and compares each result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rchc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_z_i,
  input  logic [22:0]        inner_radius_i,
  input  logic [22:0]        outer_radius_i,
  input  logic               first_of_set_i,
  input  logic [15:0]        set_size_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               result_valid_i,
  input  logic signed [23:0] kept_center_x_i,
  input  logic signed [23:0] kept_center_z_i,
  input  logic [22:0]        kept_inner_radius_i,
  input  logic [22:0]        kept_outer_radius_i,
  input  logic [15:0]        kept_position_i,
  input  logic               table_overflow_i,
  output int                 err_count_o,
  output int                 pending_o
);

  import rchc_pkg::*;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cz;
    logic [22:0]        ri;
    logic [22:0]        ro;
    logic [15:0]        pos;
    logic               ovf;
  } kept_ring_t;

  localparam int DirCos [24] = '{32768, 31651, 28378, 23170, 16384, 8481, 0, -8481,
                                 -16384, -23170, -28378, -31651, -32768, -31651,
                                 -28378, -23170, -16384, -8481, 0, 8481, 16384,
                                 23170, 28378, 31651};

  kept_ring_t          kept_q[$];
  logic signed [23:0]  tab_cx [MaxStored];
  logic signed [23:0]  tab_cz [MaxStored];
  logic [22:0]         tab_ri [MaxStored];
  logic [22:0]         tab_ro [MaxStored];
  int                  tab_count;
  int                  emit_count;
  logic                set_bypassed;
  logic                cull_on;

  assign pending_o = kept_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count_o++;
  endtask

  function automatic bit outline_covered(input longint cx, input longint cz,
                                         input longint ro);
    longint sx, sz, dx, dz, d2;
    bit     hit;
    if (tab_count == 0) return 1'b0;
    for (int k = 0; k < SampleCount; k++) begin
      sx  = cx + ((ro * DirCos[k] + 16384) >>> 15);
      sz  = cz + ((ro * DirCos[(k + 18) % 24] + 16384) >>> 15);
      hit = 1'b0;
      for (int e = 0; e < tab_count && !hit; e++) begin
        dx = longint'(tab_cx[e]) - sx;
        dz = longint'(tab_cz[e]) - sz;
        d2 = dx * dx + dz * dz;
        if (d2 <= longint'(tab_ro[e]) * longint'(tab_ro[e]) &&
            (tab_ri[e] == 0 || d2 >= longint'(tab_ri[e]) * longint'(tab_ri[e])))
          hit = 1'b1;
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_beat();
    kept_ring_t r;
    r = '{center_x_i, center_z_i, inner_radius_i, outer_radius_i, 16'd0, 1'b0};
    if (first_of_set_i) begin
      tab_count    = 0;
      emit_count   = 0;
      set_bypassed = (set_size_i <= 16'd4);
    end
    if (!set_bypassed && cull_on) begin
      if (outline_covered(center_x_i, center_z_i, outer_radius_i)) return;
      if (tab_count < MaxStored) begin
        tab_cx[tab_count] = center_x_i;
        tab_cz[tab_count] = center_z_i;
        tab_ri[tab_count] = inner_radius_i;
        tab_ro[tab_count] = outer_radius_i;
        tab_count++;
      end else begin
        r.ovf = 1'b1;
      end
    end
    r.pos = emit_count[15:0];
    if (emit_count < 65535) emit_count++;
    kept_q.insert(kept_q.size(), r);
  endtask

  initial err_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    kept_ring_t w;
    if (!rst_ni) begin
      kept_q.delete();
      tab_count    = 0;
      emit_count   = 0;
      set_bypassed = 1'b0;
      cull_on      = 1'b1;
    end else begin
      if (result_valid_i) begin
        if (kept_q.size() == 0) begin
          report("unexpected result beat, position", kept_position_i, -1);
        end else begin
          w = kept_q.pop_front();
          if (kept_center_x_i !== w.cx) report("kept_center_x", kept_center_x_i, w.cx);
          if (kept_center_z_i !== w.cz) report("kept_center_z", kept_center_z_i, w.cz);
          if (kept_inner_radius_i !== w.ri)
            report("kept_inner_radius", kept_inner_radius_i, w.ri);
          if (kept_outer_radius_i !== w.ro)
            report("kept_outer_radius", kept_outer_radius_i, w.ro);
          if (kept_position_i !== w.pos) report("kept_position", kept_position_i, w.pos);
          if (table_overflow_i !== w.ovf)
            report("table_overflow", table_overflow_i, w.ovf);
        end
      end
      if (cfg_we_i) cull_on = cfg_wdata_i;
      if (start_i && !busy_i) predict_beat();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Ring cluster hull cull testbench
// Drives directed and clustered random ring sets with random sender gaps,
// switches culling on and off between phases and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [23:0] center_x;
  logic signed [23:0] center_z;
  logic [22:0]        inner_radius;
  logic [22:0]        outer_radius;
  logic               first_of_set;
  logic [15:0]        set_size;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               result_valid;
  logic signed [23:0] kept_center_x;
  logic signed [23:0] kept_center_z;
  logic [22:0]        kept_inner_radius;
  logic [22:0]        kept_outer_radius;
  logic [15:0]        kept_position;
  logic               table_overflow;
  int                 err_count;
  int                 pending;
  int                 gap_pct;

  ring_cluster_hull_cull u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start               (start),
    .busy                (busy),
    .center_x_i          (center_x),
    .center_z_i          (center_z),
    .inner_radius_i      (inner_radius),
    .outer_radius_i      (outer_radius),
    .first_of_set_i      (first_of_set),
    .set_size_i          (set_size),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .result_valid_o      (result_valid),
    .kept_center_x_o     (kept_center_x),
    .kept_center_z_o     (kept_center_z),
    .kept_inner_radius_o (kept_inner_radius),
    .kept_outer_radius_o (kept_outer_radius),
    .kept_position_o     (kept_position),
    .table_overflow_o    (table_overflow)
  );

  rchc_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_i              (busy),
    .center_x_i          (center_x),
    .center_z_i          (center_z),
    .inner_radius_i      (inner_radius),
    .outer_radius_i      (outer_radius),
    .first_of_set_i      (first_of_set),
    .set_size_i          (set_size),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .result_valid_i      (result_valid),
    .kept_center_x_i     (kept_center_x),
    .kept_center_z_i     (kept_center_z),
    .kept_inner_radius_i (kept_inner_radius),
    .kept_outer_radius_i (kept_outer_radius),
    .kept_position_i     (kept_position),
    .table_overflow_i    (table_overflow),
    .err_count_o         (err_count),
    .pending_o           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic send_ring(input logic signed [23:0] cx, input logic signed [23:0] cz,
                           input logic [22:0] ri, input logic [22:0] ro,
                           input logic first, input logic [15:0] size);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    center_x     <= cx;
    center_z     <= cz;
    inner_radius <= ri;
    outer_radius <= ro;
    first_of_set <= first;
    set_size     <= size;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (7000) @(posedge clk);
  endtask

  task automatic write_cull(input logic en);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic noise_ring();
    send_ring(24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
              ($urandom_range(19) == 0), 16'($urandom));
  endtask

  // A large ring opens each set; later rings cluster around it so that many of
  // their outlines end up covered by what the set has already kept.
  task automatic ring_set(input int n);
    logic signed [23:0] bx, bz;
    logic [22:0]        big, r, hole;
    logic [15:0]        size;
    bx   = 24'($urandom_range(0, 8_000_000) - 4_000_000);
    bz   = 24'($urandom_range(0, 8_000_000) - 4_000_000);
    big  = 23'($urandom_range(2000, 200_000));
    hole = ($urandom_range(3) == 0) ? 23'($urandom_range(1, big / 2)) : 23'd0;
    case ($urandom_range(9))
      0:       size = 16'($urandom_range(0, 4));
      1:       size = 16'($urandom);
      default: size = 16'(n);
    endcase
    send_ring(bx, bz, hole, big, 1'b1, size);
    for (int i = 1; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        noise_ring();
      end else begin
        r = 23'($urandom_range(0, big / 2));
        hole = ($urandom_range(4) == 0) ? 23'($urandom_range(0, r)) : 23'd0;
        send_ring(24'(bx + $signed($urandom_range(0, big)) - $signed(big / 2)),
                  24'(bz + $signed($urandom_range(0, big)) - $signed(big / 2)),
                  hole, r, 1'b0, size);
      end
    end
  endtask

  task automatic random_phase(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      automatic int n = $urandom_range(2, 30);
      ring_set(n);
      sent += n;
    end
  endtask

  initial begin
    start        = 1'b0;
    center_x     = '0;
    center_z     = '0;
    inner_radius = '0;
    outer_radius = '0;
    first_of_set = 1'b0;
    set_size     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    gap_pct      = 17;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rings before any set has been opened, then bypassed and culled sets.
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd256, 1'b0, 16'd0);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd128, 1'b0, 16'd0);
    send_ring(-24'sd8388608, 24'sd8388607, 23'h7FFFFF, 23'h7FFFFF, 1'b1, 16'd4);
    send_ring(24'sd5, 24'sd5, 23'd0, 23'd0, 1'b0, 16'd0);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'h7FFFFF, 1'b1, 16'd5);
    send_ring(24'sd1000, -24'sd1000, 23'd0, 23'd2000, 1'b0, 16'd5);
    send_ring(24'sd8388607, -24'sd8388608, 23'd0, 23'd0, 1'b0, 16'd5);
    send_ring(24'sd0, 24'sd0, 23'd50000, 23'd100000, 1'b1, 16'd100);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd1000, 1'b0, 16'd100);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd75000, 1'b0, 16'd100);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd0, 1'b0, 16'd100);
    send_ring(24'sd20000, 24'sd0, 23'd0, 23'd50000, 1'b0, 16'd100);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd100, 1'b1, 16'd0);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd100, 1'b0, 16'd0);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd100, 1'b1, 16'hFFFF);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd50, 1'b0, 16'hFFFF);
    write_cull(1'b0);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd100, 1'b1, 16'd9);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd50, 1'b0, 16'd9);
    write_cull(1'b1);
    send_ring(24'sd0, 24'sd0, 23'd0, 23'd50, 1'b0, 16'd9);

    // Disjoint small rings fill the table and then overflow it.
    gap_pct = 0;
    for (int i = 0; i < 262; i++)
      send_ring(24'(i * 4096) - 24'sd4000000, 24'sd12345, 23'd0, 23'd256,
                (i == 0), 16'd300);

    gap_pct = 17;
    write_cull(1'b1);
    random_phase(130);
    gap_pct = 47;
    write_cull(1'b0);
    random_phase(60);
    write_cull(1'b1);
    random_phase(130);
    gap_pct = 0;
    random_phase(130);

    wait_quiet();
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rchc_pkg.sv
rtl/core/rchc_ram.sv
rtl/core/rchc_front.sv
rtl/core/rchc_back.sv
rtl/core/ring_cluster_hull_cull.sv
tb/rchc_checker.sv
tb/testbench.sv
